>>> rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 byte stream hash
// Block entry type, queue status type, initial chaining words, round constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  typedef struct packed {
    logic [511:0] data;
    logic         last;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

`default_nettype wire

>>> rtl/core/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front: byte packer and padder
// Packs bytes big-endian into a 64-byte block, counts the bit length and
// hands full or padded blocks to the block queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        msg_byte,
  input  logic              byte_valid,
  input  logic              end_of_message,
  input  logic              push,
  output logic              full,
  output logic              q_push,
  output sha1_pkg::blk_t    q_data,
  input  sha1_pkg::q_stat_t q_stat
);
  import sha1_pkg::*;

  logic [511:0] buf_data;
  logic [5:0]   pos;
  logic [63:0]  len;
  logic         pend_valid;
  logic         pend_pad;
  logic [63:0]  pend_len;

  logic         accept;
  logic [511:0] blk_in;
  logic [511:0] pad;
  logic [511:0] pad_len;
  logic [511:0] pend_blk;
  logic [5:0]   pos_a;
  logic [63:0]  len_a;
  logic         blk_full;

  assign full   = pend_valid || q_stat.full;
  assign accept = push && !full;

  always_comb begin
    blk_in = buf_data;
    for (int p = 0; p < 64; p++) begin
      if (byte_valid && pos == 6'(p)) begin
        blk_in[511 - 8*p -: 8] = msg_byte;
      end
    end
  end

  assign pos_a    = byte_valid ? pos + 6'd1 : pos;
  assign len_a    = byte_valid ? len + 64'd8 : len;
  assign blk_full = byte_valid && (pos == 6'd63);

  always_comb begin
    pad = blk_in;
    for (int p = 0; p < 64; p++) begin
      if (6'(p) == pos_a) begin
        pad[511 - 8*p -: 8] = PAD_BYTE;
      end else if (6'(p) > pos_a) begin
        pad[511 - 8*p -: 8] = 8'h00;
      end
    end
  end

  assign pad_len  = {pad[511:64], len_a};
  assign pend_blk = {(pend_pad ? PAD_BYTE : 8'h00), 440'd0, pend_len};

  always_comb begin
    q_push      = 1'b0;
    q_data.data = blk_in;
    q_data.last = 1'b0;
    if (pend_valid) begin
      q_push      = !q_stat.full;
      q_data.data = pend_blk;
      q_data.last = 1'b1;
    end else if (accept) begin
      if (end_of_message) begin
        q_push = 1'b1;
        if (blk_full) begin
          q_data.data = blk_in;
        end else if (pos_a > 6'd55) begin
          q_data.data = pad;
        end else begin
          q_data.data = pad_len;
          q_data.last = 1'b1;
        end
      end else if (blk_full) begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 6'd0;
      len        <= 64'd0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_stat.full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (end_of_message) begin
          pos        <= 6'd0;
          len        <= 64'd0;
          pend_valid <= blk_full || (pos_a > 6'd55);
        end else begin
          pos <= pos_a;
          len <= len_a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_data <= blk_in;
      pend_pad <= blk_full;
      pend_len <= len_a;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sha1_queue.sv
// ----------------------------------------------------------------------------
// sha1_queue: block queue
// Short first-in first-out store of 512-bit blocks between packer and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha1_pkg::blk_t    wdata,
  input  logic              pop,
  output sha1_pkg::blk_t    rdata,
  output sha1_pkg::q_stat_t stat
);
  import sha1_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blk_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign rdata      = entries[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back: compression engine and digest register
// Runs one SHA-1 round per cycle over a 16-word schedule window, folds the
// result into the chaining words and holds the digest until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_back (
  input  logic              clk,
  input  logic              rst,
  input  sha1_pkg::blk_t    head,
  input  sha1_pkg::q_stat_t q_stat,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [31:0]       hash_word0,
  output logic [31:0]       hash_word1,
  output logic [31:0]       hash_word2,
  output logic [31:0]       hash_word3,
  output logic [31:0]       hash_word4
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [6:0]  rnd;
  logic [31:0] win [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [31:0] hout [5];
  logic        last_r;
  logic        out_valid;

  logic [31:0] wt;
  logic [31:0] wx;
  logic [31:0] wnew;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [31:0] hsum [5];
  logic        start;

  assign start = (state == ST_IDLE) && !q_stat.empty && (!head.last || !out_valid);
  assign q_pop = start;
  assign empty = !out_valid;

  assign hash_word0 = hout[0];
  assign hash_word1 = hout[1];
  assign hash_word2 = hout[2];
  assign hash_word3 = hout[3];
  assign hash_word4 = hout[4];

  assign wt   = win[0];
  assign wx   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
      k = SHA1_K0;
    end else if (rnd inside {[7'd20:7'd39]}) begin
      f = b ^ c ^ d;
      k = SHA1_K1;
    end else if (rnd inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
      k = SHA1_K2;
    end else begin
      f = b ^ c ^ d;
      k = SHA1_K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + wt + k;

  assign hsum[0] = h[0] + a;
  assign hsum[1] = h[1] + b;
  assign hsum[2] = h[2] + c;
  assign hsum[3] = h[3] + d;
  assign hsum[4] = h[4] + e;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_ROUND;
      ST_ROUND: if (rnd == 7'd79) state_next = ST_FIN;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= 7'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= SHA1_IV[i];
      end
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= 7'd0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 7'd1;
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (state == ST_FIN) begin
        for (int i = 0; i < 5; i++) begin
          h[i] <= last_r ? SHA1_IV[i] : hsum[i];
        end
        if (last_r) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        win[i] <= head.data[511 - 32*i -: 32];
      end
      a      <= h[0];
      b      <= h[1];
      c      <= h[2];
      d      <= h[3];
      e      <= h[4];
      last_r <= head.last;
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= wnew;
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    if (state == ST_FIN && last_r) begin
      for (int i = 0; i < 5; i++) begin
        hout[i] <= hsum[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sha1_byte_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hash_top: SHA-1 hash over a stream of message bytes
// One byte per cycle is taken while the block queue has room and no pending
// end block waits. The round engine works each 64-byte block through load,
// 80 rounds and fold before it pops the next one, while the packer goes on
// filling the queue. The digest is registered at the fold of the final block.
// Synchronous reset clears pointers, counters and flags and loads the IV.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hash_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  msg_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_word0,
  output logic [31:0] hash_word1,
  output logic [31:0] hash_word2,
  output logic [31:0] hash_word3,
  output logic [31:0] hash_word4
);
  import sha1_pkg::*;

  logic    q_push;
  logic    q_pop;
  blk_t    q_wdata;
  blk_t    q_rdata;
  q_stat_t q_stat;

  sha1_front u_front (
    .clk            (clk),
    .rst            (rst),
    .msg_byte       (msg_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_stat         (q_stat)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sha1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .hash_word0 (hash_word0),
    .hash_word1 (hash_word1),
    .hash_word2 (hash_word2),
    .hash_word3 (hash_word3),
    .hash_word4 (hash_word4)
  );

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("block pushed into full queue");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("block popped from empty queue");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not idle after reset");

endmodule

`default_nettype wire
